// ----- hdl/pointer_report_to_aim_stick_assert.svh -----
// assertion macros for the pointer report to aim stick block
// used by pointer_report_to_aim_stick.sv, expects clk_i and rst_ni in scope
`ifndef POINTER_REPORT_TO_AIM_STICK_ASSERT_SVH
`define POINTER_REPORT_TO_AIM_STICK_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked only out of reset
`define PRTA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked at every edge, reset included
`define PRTA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define PRTA_ASSERT(label, prop, msg)
`define PRTA_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- hdl/ptraim_pkg.sv -----
// shared types and constants for the pointer report to aim stick block
// no dependencies
package ptraim_pkg;

  localparam logic [7:0] ID_BUTTONS = 8'd1;
  localparam logic [7:0] ID_MOTION  = 8'd2;

  localparam logic [7:0] LEN_BUTTONS_MIN = 8'd2;
  localparam logic [7:0] LEN_WHEEL_MIN   = 8'd3;
  localparam logic [7:0] LEN_MOTION_MIN  = 8'd4;

  localparam logic [1:0] MODE_PASS  = 2'd0;
  localparam logic [1:0] MODE_RIGHT = 2'd1;
  localparam logic [1:0] MODE_LEFT  = 2'd2;

  localparam logic       REG_MODE      = 1'b0;
  localparam logic       REG_DEAD_ZONE = 1'b1;

  localparam logic [10:0] DEAD_ZONE_RESET = 11'd2;

  localparam logic signed [12:0] AIM_LIMIT = 13'sd127;
  localparam logic [7:0]         CENTRE    = 8'd128;

  typedef struct packed {
    logic        clear;
    logic [10:0] dead_zone;
  } axis_ctrl_t;

endpackage

// ----- hdl/ptraim_axis.sv -----
// one aim axis: deadzone, halving toward zero and clamped accumulate, or zero while clear is set
// depends on ptraim_pkg
module ptraim_axis
  import ptraim_pkg::*;
(
  input  axis_ctrl_t        ctrl_i,
  input  logic signed [11:0] delta_i,
  input  logic signed [7:0]  aim_i,
  output logic signed [7:0]  aim_o
);

  logic signed [12:0] delta_wide;
  logic        [12:0] mag;
  logic signed [12:0] rounded;
  logic signed [12:0] half;
  logic signed [12:0] filtered;
  logic signed [12:0] sum;
  logic signed [12:0] clamped;

  always_comb begin
    delta_wide = 13'(delta_i);
    mag        = delta_i[11] ? 13'(-delta_wide) : 13'(delta_wide);
    // bias negatives by one so the shift truncates toward zero
    rounded    = delta_wide + 13'(delta_i[11]);
    half       = rounded >>> 1;
    filtered   = (mag < {2'b00, ctrl_i.dead_zone}) ? 13'sd0 : half;
    sum        = 13'(aim_i) + filtered;
    if (sum > AIM_LIMIT) begin
      clamped = AIM_LIMIT;
    end else if (sum < -AIM_LIMIT) begin
      clamped = -AIM_LIMIT;
    end else begin
      clamped = sum;
    end
    aim_o = ctrl_i.clear ? 8'sd0 : clamped[7:0];
  end

endmodule

// ----- hdl/pointer_report_to_aim_stick.sv -----
// channel | dir | fields (lsb first)
// s_axis  | in  | tdata: hid_id 8, length 8, byte_one 8, byte_two 8, byte_three 8
// m_axis  | out | tdata: buttons 5, delta_x 12, delta_y 12, wheel 8, left_x 8,
//         |     |        left_y 8, right_x 8, right_y 8, 3 zero pad bits
// cfg     | in  | cfg_index 0 mode, 1 dead_zone; cfg_data 11 bits
//
// one report per cycle while the output is not stalled: input register, state update, output register
// m_axis valid rises when the accepted report moves from the input register into the output register
// the aim accumulate and clamp in ptraim_axis set the critical path
// async active-low reset: mode right stick, dead zone 2, sticks centred
// an output stall holds the input register; short or unknown reports drop silently
// depends on ptraim_pkg, ptraim_axis and pointer_report_to_aim_stick_assert.svh
`include "pointer_report_to_aim_stick_assert.svh"

module pointer_report_to_aim_stick
  import ptraim_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // hid_id, length, byte_one, byte_two, byte_three
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // buttons, delta_x, delta_y, wheel, left_x, left_y,
                                     // right_x, right_y, zero pad
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [10:0] cfg_data_i
);

  // input register
  logic       in_valid_q;
  logic [7:0] id_q, len_q, b1_q, b2_q, b3_q;

  // block state
  logic [1:0]        mode_q;
  logic [10:0]       dead_zone_q;
  logic [7:0]        raw_q, raw_d;
  logic signed [7:0] aim_x_q, aim_x_d, aim_y_q, aim_y_d;
  logic [7:0]        lx_q, lx_d, ly_q, ly_d, rx_q, rx_d, ry_q, ry_d;

  // output register
  logic              out_valid_q;
  logic [4:0]        o_buttons_q, o_buttons_d;
  logic signed [11:0] o_dx_q, o_dx_d, o_dy_q, o_dy_d;
  logic signed [7:0] o_wheel_q, o_wheel_d;

  logic advance, process, has_result, cfg_fire;
  logic mode_write, state_en;
  logic is_buttons, is_motion, stick_mode;
  logic signed [11:0] dx, dy;
  logic signed [7:0]  acc_x, acc_y;
  axis_ctrl_t axis_ctrl;

  assign advance       = !out_valid_q || m_axis_tready;
  assign process       = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;
  assign cfg_fire      = cfg_valid_i && cfg_ready_o;
  assign mode_write    = cfg_fire && (cfg_index_i == REG_MODE);
  assign state_en      = process || mode_write;

  assign is_buttons = (id_q == ID_BUTTONS) && (len_q >= LEN_BUTTONS_MIN);
  assign is_motion  = (id_q == ID_MOTION) && (len_q >= LEN_MOTION_MIN);
  assign has_result = is_buttons || is_motion;
  assign stick_mode = (mode_q != MODE_PASS);

  assign dx = {b2_q[3:0], b1_q};
  assign dy = {b3_q, b2_q[7:4]};

  assign axis_ctrl.clear     = raw_q[0];
  assign axis_ctrl.dead_zone = dead_zone_q;

  ptraim_axis u_axis_x (
    .ctrl_i  (axis_ctrl),
    .delta_i (dx),
    .aim_i   (aim_x_q),
    .aim_o   (acc_x)
  );

  ptraim_axis u_axis_y (
    .ctrl_i  (axis_ctrl),
    .delta_i (dy),
    .aim_i   (aim_y_q),
    .aim_o   (acc_y)
  );

  always_comb begin
    raw_d     = raw_q;
    aim_x_d   = aim_x_q;
    aim_y_d   = aim_y_q;
    lx_d      = lx_q;
    ly_d      = ly_q;
    rx_d      = rx_q;
    ry_d      = ry_q;
    o_dx_d    = 12'sd0;
    o_dy_d    = 12'sd0;
    o_wheel_d = 8'sd0;
    if (process && is_buttons) begin
      raw_d = b1_q;
      // rising left click recentres in a stick mode
      if (stick_mode && b1_q[0] && !raw_q[0]) begin
        aim_x_d = 8'sd0;
        aim_y_d = 8'sd0;
        lx_d    = CENTRE;
        ly_d    = CENTRE;
        rx_d    = CENTRE;
        ry_d    = CENTRE;
      end
      if (len_q >= LEN_WHEEL_MIN) begin
        o_wheel_d = b2_q;
      end
    end else if (process && is_motion) begin
      if (!stick_mode) begin
        o_dx_d = dx;
        o_dy_d = dy;
      end else begin
        aim_x_d = acc_x;
        aim_y_d = acc_y;
        if (mode_q == MODE_LEFT) begin
          lx_d = 8'(acc_x) + CENTRE;
          ly_d = 8'(acc_y) + CENTRE;
        end else begin
          rx_d = 8'(acc_x) + CENTRE;
          ry_d = 8'(acc_y) + CENTRE;
        end
      end
    end
    // a mode write recentres the aim and all sticks
    if (mode_write) begin
      aim_x_d = 8'sd0;
      aim_y_d = 8'sd0;
      lx_d    = CENTRE;
      ly_d    = CENTRE;
      rx_d    = CENTRE;
      ry_d    = CENTRE;
    end
    o_buttons_d = {raw_d[4:1], raw_d[0] && !stick_mode};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_RIGHT;
      dead_zone_q <= DEAD_ZONE_RESET;
      raw_q       <= 8'd0;
      aim_x_q     <= 8'sd0;
      aim_y_q     <= 8'sd0;
      lx_q        <= CENTRE;
      ly_q        <= CENTRE;
      rx_q        <= CENTRE;
      ry_q        <= CENTRE;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (process) begin
        in_valid_q <= 1'b0;
      end
      if (process) begin
        out_valid_q <= has_result;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (state_en) begin
        raw_q   <= raw_d;
        aim_x_q <= aim_x_d;
        aim_y_q <= aim_y_d;
        lx_q    <= lx_d;
        ly_q    <= ly_d;
        rx_q    <= rx_d;
        ry_q    <= ry_d;
      end
      if (cfg_fire) begin
        case (cfg_index_i)
          REG_MODE: begin
            mode_q <= cfg_data_i[1:0];
          end
          REG_DEAD_ZONE: begin
            dead_zone_q <= cfg_data_i;
          end
          default: begin
            dead_zone_q <= dead_zone_q;
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      id_q  <= s_axis_tdata[7:0];
      len_q <= s_axis_tdata[15:8];
      b1_q  <= s_axis_tdata[23:16];
      b2_q  <= s_axis_tdata[31:24];
      b3_q  <= s_axis_tdata[39:32];
    end
    if (process) begin
      o_buttons_q <= o_buttons_d;
      o_dx_q      <= o_dx_d;
      o_dy_q      <= o_dy_d;
      o_wheel_q   <= o_wheel_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, ry_q, rx_q, ly_q, lx_q, o_wheel_q, o_dy_q, o_dx_q,
                          o_buttons_q};

  // clamp never lets the aim reach the most negative code
  `PRTA_ASSERT(aim_x_range, aim_x_q != -8'sd128, "aim x outside clamp range")
  `PRTA_ASSERT(aim_y_range, aim_y_q != -8'sd128, "aim y outside clamp range")
  // passthrough leaves the aim at rest
  `PRTA_ASSERT(pass_aim_rest, (mode_q == MODE_PASS) |-> (aim_x_q == 8'sd0 && aim_y_q == 8'sd0),
               "aim moved in passthrough mode")
  // only the selected stick moves
  `PRTA_ASSERT(left_mode_right_centred,
               (mode_q == MODE_LEFT) |-> (rx_q == CENTRE && ry_q == CENTRE),
               "right stick moved in left stick mode")
  `PRTA_ASSERT(right_mode_left_centred,
               (mode_q != MODE_LEFT) |-> (lx_q == CENTRE && ly_q == CENTRE),
               "left stick moved outside left stick mode")

endmodule

// ----- dv/pointer_report_to_aim_stick_tb.sv -----
// testbench for pointer_report_to_aim_stick: drives hid reports and register writes,
// predicts every output frame and compares it field by field
// depends on ptraim_pkg and the pointer_report_to_aim_stick rtl
`timescale 1ns / 100ps

module pointer_report_to_aim_stick_tb
  import ptraim_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_COUNT = 8;
  localparam int PHASE_REPORTS = 150;
  localparam int HOLD_OFF_CYCLES = 80;

  // m_axis tdata layout, msb first
  typedef struct packed {
    logic [2:0]  pad;
    logic [7:0]  right_y;
    logic [7:0]  right_x;
    logic [7:0]  left_y;
    logic [7:0]  left_x;
    logic [7:0]  wheel;
    logic [11:0] delta_y;
    logic [11:0] delta_x;
    logic [4:0]  buttons;
  } stick_frame_t;

  class report_scoreboard;
    logic [1:0]   mode;
    logic [10:0]  dead_zone;
    logic [7:0]   raw_buttons;
    int           aim_h;
    int           aim_v;
    logic [7:0]   sticks [4];  // left_x, left_y, right_x, right_y
    stick_frame_t expected_frames [$];
    int           failures;

    function new();
      mode = MODE_RIGHT;
      dead_zone = DEAD_ZONE_RESET;
      raw_buttons = 8'd0;
      failures = 0;
      recentre();
    endfunction

    function void recentre();
      aim_h = 0;
      aim_v = 0;
      foreach (sticks[i]) sticks[i] = CENTRE;
    endfunction

    function void write_reg(logic index, logic [10:0] data);
      if (index == REG_MODE) begin
        mode = data[1:0];
        recentre();
      end else begin
        dead_zone = data;
      end
    endfunction

    function int filter_delta(int d);
      int mag;
      mag = (d < 0) ? -d : d;
      if (mag < int'(dead_zone)) return 0;
      return d / 2;
    endfunction

    function int clamp_aim(int a);
      if (a > int'(AIM_LIMIT)) return int'(AIM_LIMIT);
      if (a < -int'(AIM_LIMIT)) return -int'(AIM_LIMIT);
      return a;
    endfunction

    function void push_frame(int dx, int dy, logic [7:0] wheel);
      stick_frame_t f;
      f.pad = 3'd0;
      f.buttons = {raw_buttons[4:1], (mode == MODE_PASS) ? raw_buttons[0] : 1'b0};
      f.delta_x = dx[11:0];
      f.delta_y = dy[11:0];
      f.wheel = wheel;
      f.left_x = sticks[0];
      f.left_y = sticks[1];
      f.right_x = sticks[2];
      f.right_y = sticks[3];
      expected_frames.push_back(f);
    endfunction

    // works out the frame, if any, caused by one accepted report
    function void predict_report(logic [39:0] tdata);
      logic [7:0] id, len, b1, b2, b3, prev;
      int dx, dy, base;
      {b3, b2, b1, len, id} = tdata;
      if (id == ID_BUTTONS) begin
        if (len < LEN_BUTTONS_MIN) return;
        prev = raw_buttons;
        raw_buttons = b1;
        if (mode != MODE_PASS && b1[0] && !prev[0]) recentre();
        push_frame(0, 0, (len >= LEN_WHEEL_MIN) ? b2 : 8'd0);
      end else if (id == ID_MOTION) begin
        if (len < LEN_MOTION_MIN) return;
        dx = $signed({b2[3:0], b1});
        dy = $signed({b3, b2[7:4]});
        if (mode == MODE_PASS) begin
          push_frame(dx, dy, 8'd0);
          return;
        end
        if (raw_buttons[0]) begin
          aim_h = 0;
          aim_v = 0;
        end else begin
          aim_h = clamp_aim(aim_h + filter_delta(dx));
          aim_v = clamp_aim(aim_v + filter_delta(dy));
        end
        base = (mode == MODE_LEFT) ? 0 : 2;
        sticks[base] = CENTRE + aim_h[7:0];
        sticks[base + 1] = CENTRE + aim_v[7:0];
        push_frame(0, 0, 8'd0);
      end
    endfunction

    function void check_field(string field, logic [11:0] want, logic [11:0] got);
      if (want !== got) begin
        failures++;
        $display("%0t: %s expected %0h got %0h", $time, field, want, got);
      end
    endfunction

    function void check_frame(logic [71:0] tdata);
      stick_frame_t got, want;
      got = tdata;
      if (expected_frames.size() == 0) begin
        failures++;
        $display("%0t: frame expected none got %0h", $time, tdata);
        return;
      end
      want = expected_frames.pop_front();
      check_field("buttons", 12'(want.buttons), 12'(got.buttons));
      check_field("delta_x", want.delta_x, got.delta_x);
      check_field("delta_y", want.delta_y, got.delta_y);
      check_field("wheel", 12'(want.wheel), 12'(got.wheel));
      check_field("left_x", 12'(want.left_x), 12'(got.left_x));
      check_field("left_y", 12'(want.left_y), 12'(got.left_y));
      check_field("right_x", 12'(want.right_x), 12'(got.right_x));
      check_field("right_y", 12'(want.right_y), 12'(got.right_y));
      check_field("pad", 12'(want.pad), 12'(got.pad));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // hid_id, length, byte_one, byte_two, byte_three
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // buttons, delta_x, delta_y, wheel, left_x, left_y,
                               // right_x, right_y, zero pad
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [10:0] cfg_data_i;

  report_scoreboard sb;
  int idle_pct = 14;
  bit hold_off_req = 1'b0;
  int cycle_count = 0;

  pointer_report_to_aim_stick uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // results are checked before the input transfer of the same edge is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_frame(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.predict_report(s_axis_tdata);
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
    end
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_report(logic [7:0] id, logic [7:0] len, logic [7:0] b1,
                             logic [7:0] b2, logic [7:0] b3);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {b3, b2, b1, len, id};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic index, logic [10:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = index;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // let every frame come out, then cover reports still in flight that give none
  task automatic drain_block();
    s_axis_tvalid = 1'b0;
    while (sb.expected_frames.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  initial begin
    int pick, counted, dx, dy;
    logic [7:0] id, len, b1, b2, b3;
    logic [10:0] dz;
    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_MODE;
    cfg_data_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: right stick, dead zone 2
    send_report(ID_MOTION, 8'd4, 8'hFF, 8'h07, 8'h80);   // full scale, clamps both ways
    send_report(ID_MOTION, 8'd4, 8'h01, 8'h00, 8'h00);   // inside dead zone
    send_report(ID_MOTION, 8'd4, 8'hFD, 8'h0F, 8'h00);   // -3 halves to -1
    send_report(ID_BUTTONS, 8'd0, 8'h01, 8'h00, 8'h00);
    send_report(ID_BUTTONS, 8'd1, 8'h01, 8'h00, 8'h00);
    send_report(ID_MOTION, 8'd3, 8'hFF, 8'hFF, 8'hFF);
    send_report(8'd0, 8'd4, 8'hAA, 8'h55, 8'hAA);
    send_report(8'd3, 8'd4, 8'h12, 8'h34, 8'h56);
    send_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_report(ID_BUTTONS, 8'd2, 8'h1F, 8'h55, 8'h00);  // rising left, no wheel byte
    send_report(ID_MOTION, 8'd4, 8'h40, 8'h00, 8'h04);   // left held
    send_report(ID_BUTTONS, 8'd3, 8'hFE, 8'h80, 8'h00);
    send_report(ID_MOTION, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_report(ID_BUTTONS, 8'hFF, 8'h00, 8'h7F, 8'hFF);
    drain_block();
    write_reg(REG_MODE, {9'h1AA, MODE_PASS});
    send_report(ID_MOTION, 8'd4, 8'hFF, 8'h07, 8'h80);
    send_report(ID_MOTION, 8'd4, 8'h00, 8'hF8, 8'h7F);
    send_report(ID_BUTTONS, 8'd3, 8'h01, 8'h01, 8'h00);  // left shows, no recentre
    drain_block();
    write_reg(REG_MODE, {9'd0, MODE_LEFT});
    write_reg(REG_DEAD_ZONE, 11'd0);
    send_report(ID_BUTTONS, 8'd2, 8'h00, 8'h00, 8'h00);
    send_report(ID_MOTION, 8'd4, 8'h01, 8'hF0, 8'hFF);   // +1 and -1 pass, halve to 0
    send_report(ID_MOTION, 8'd4, 8'h50, 8'h00, 8'h00);
    drain_block();
    write_reg(REG_MODE, 11'h7FF);                        // mode three
    write_reg(REG_DEAD_ZONE, 11'h7FF);
    send_report(ID_MOTION, 8'd4, 8'hFF, 8'h07, 8'h80);
    send_report(ID_MOTION, 8'd4, 8'hFE, 8'hF7, 8'h7F);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain_block();
      if (p == 3) dz = 11'h7FF;
      else if (p == 5) dz = 11'd0;
      else dz = 11'($urandom_range(0, 16));
      write_reg(REG_MODE, {9'($urandom), 2'(p % 4)});
      write_reg(REG_DEAD_ZONE, dz);
      idle_pct = (p == 4) ? 0 : 14;
      if (p == 1) hold_off_req = 1'b1;
      counted = 0;
      while (counted < PHASE_REPORTS) begin
        pick = $urandom_range(0, 99);
        b1 = 8'($urandom);
        b2 = 8'($urandom);
        b3 = 8'($urandom);
        if (pick < 45) begin
          id = ID_MOTION;
          len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(4, 255)) : LEN_MOTION_MIN;
          // mostly small motion so the aim wanders instead of pinning
          if ($urandom_range(0, 2) != 0) begin
            dx = $urandom_range(0, 80) - 40;
            dy = $urandom_range(0, 80) - 40;
            b1 = dx[7:0];
            b2 = {dy[3:0], dx[11:8]};
            b3 = dy[11:4];
          end
        end else if (pick < 75) begin
          id = ID_BUTTONS;
          len = (pick < 70) ? LEN_WHEEL_MIN : 8'($urandom_range(2, 255));
          b1[0] = ($urandom_range(0, 99) < 30);
        end else if (pick < 88) begin
          if (pick[0]) begin
            id = ID_BUTTONS;
            len = 8'($urandom_range(0, 1));
          end else begin
            id = ID_MOTION;
            len = 8'($urandom_range(0, 3));
          end
        end else begin
          do id = 8'($urandom); while (id == ID_BUTTONS || id == ID_MOTION);
          len = 8'($urandom);
        end
        send_report(id, len, b1, b2, b3);
        counted++;
      end
    end
    idle_pct = 14;
    drain_block();

    if (sb.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
